@@ rtl/pse_pkg.sv @@
// pse_pkg: shared constants, control word type and microprogram for the postfix evaluator
// used by postfix_stack_evaluator; no dependencies
package pse_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int VALUE_BITS      = 16;
	localparam int ERR_W           = 3;
	localparam int UPC_W           = 4;
	localparam int ACT_W           = 4;
	localparam int JMP_W           = 4;

	localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_DIVZERO   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd4;

	localparam logic [7:0] ASC_PLUS  = 8'h2B;
	localparam logic [7:0] ASC_MINUS = 8'h2D;
	localparam logic [7:0] ASC_STAR  = 8'h2A;
	localparam logic [7:0] ASC_SLASH = 8'h2F;
	localparam logic [7:0] ASC_ZERO  = 8'h30;
	localparam logic [7:0] ASC_NINE  = 8'h39;
	localparam logic [7:0] ASC_SPACE = 8'h20;

	// datapath actions
	localparam logic [ACT_W-1:0] A_NONE       = 4'd0;
	localparam logic [ACT_W-1:0] A_PUSH_DIGIT = 4'd1;
	localparam logic [ACT_W-1:0] A_ERR_UNKN   = 4'd2;
	localparam logic [ACT_W-1:0] A_CHK_OPS    = 4'd3;
	localparam logic [ACT_W-1:0] A_LD_X1      = 4'd4;
	localparam logic [ACT_W-1:0] A_LD_X2      = 4'd5;
	localparam logic [ACT_W-1:0] A_PUSH_ALU   = 4'd6;
	localparam logic [ACT_W-1:0] A_DIV_START  = 4'd7;
	localparam logic [ACT_W-1:0] A_PUSH_QUOT  = 4'd8;
	localparam logic [ACT_W-1:0] A_RD_TOP     = 4'd9;
	localparam logic [ACT_W-1:0] A_EMIT       = 4'd10;

	// sequencer jumps
	localparam logic [JMP_W-1:0] J_NEXT       = 4'd0;
	localparam logic [JMP_W-1:0] J_GOTO       = 4'd1;
	localparam logic [JMP_W-1:0] J_DISPATCH   = 4'd2;
	localparam logic [JMP_W-1:0] J_IF_UNDER   = 4'd3;
	localparam logic [JMP_W-1:0] J_IF_DIV     = 4'd4;
	localparam logic [JMP_W-1:0] J_IF_ZERO    = 4'd5;
	localparam logic [JMP_W-1:0] J_WAIT_DIV   = 4'd6;
	localparam logic [JMP_W-1:0] J_IF_NOTLAST = 4'd7;
	localparam logic [JMP_W-1:0] J_WAIT_OUT   = 4'd8;

	// program addresses
	localparam logic [UPC_W-1:0] UA_IDLE  = 4'd0;
	localparam logic [UPC_W-1:0] UA_SPACE = 4'd1;
	localparam logic [UPC_W-1:0] UA_DIGIT = 4'd2;
	localparam logic [UPC_W-1:0] UA_UNKN  = 4'd3;
	localparam logic [UPC_W-1:0] UA_OP0   = 4'd4;
	localparam logic [UPC_W-1:0] UA_OP1   = 4'd5;
	localparam logic [UPC_W-1:0] UA_OP2   = 4'd6;
	localparam logic [UPC_W-1:0] UA_OP3   = 4'd7;
	localparam logic [UPC_W-1:0] UA_DV0   = 4'd8;
	localparam logic [UPC_W-1:0] UA_DV1   = 4'd9;
	localparam logic [UPC_W-1:0] UA_DV2   = 4'd10;
	localparam logic [UPC_W-1:0] UA_FIN   = 4'd11;
	localparam logic [UPC_W-1:0] UA_EMIT  = 4'd12;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [JMP_W-1:0] jmp;
		logic [UPC_W-1:0] tgt;
	} uword_t;

	function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
		uword_t w;
		w = '{act: A_NONE, jmp: J_GOTO, tgt: UA_IDLE};
		unique case (addr)
			UA_IDLE:  w = '{act: A_NONE,       jmp: J_DISPATCH,   tgt: UA_IDLE};
			UA_SPACE: w = '{act: A_NONE,       jmp: J_GOTO,       tgt: UA_FIN};
			UA_DIGIT: w = '{act: A_PUSH_DIGIT, jmp: J_GOTO,       tgt: UA_FIN};
			UA_UNKN:  w = '{act: A_ERR_UNKN,   jmp: J_GOTO,       tgt: UA_FIN};
			UA_OP0:   w = '{act: A_CHK_OPS,    jmp: J_IF_UNDER,   tgt: UA_FIN};
			UA_OP1:   w = '{act: A_LD_X1,      jmp: J_NEXT,       tgt: UA_IDLE};
			UA_OP2:   w = '{act: A_LD_X2,      jmp: J_IF_DIV,     tgt: UA_DV0};
			UA_OP3:   w = '{act: A_PUSH_ALU,   jmp: J_GOTO,       tgt: UA_FIN};
			UA_DV0:   w = '{act: A_DIV_START,  jmp: J_IF_ZERO,    tgt: UA_FIN};
			UA_DV1:   w = '{act: A_NONE,       jmp: J_WAIT_DIV,   tgt: UA_IDLE};
			UA_DV2:   w = '{act: A_PUSH_QUOT,  jmp: J_GOTO,       tgt: UA_FIN};
			UA_FIN:   w = '{act: A_RD_TOP,     jmp: J_IF_NOTLAST, tgt: UA_IDLE};
			UA_EMIT:  w = '{act: A_EMIT,       jmp: J_WAIT_OUT,   tgt: UA_IDLE};
			default:  w = '{act: A_NONE,       jmp: J_GOTO,       tgt: UA_IDLE};
		endcase
		return w;
	endfunction

	// entry point of the routine for one symbol
	function automatic logic [UPC_W-1:0] dispatch(input logic [7:0] sym);
		logic [UPC_W-1:0] a;
		a = UA_UNKN;
		if (sym == ASC_SPACE)
			a = UA_SPACE;
		else if (sym >= ASC_ZERO && sym <= ASC_NINE)
			a = UA_DIGIT;
		else if (sym == ASC_PLUS || sym == ASC_MINUS || sym == ASC_STAR || sym == ASC_SLASH)
			a = UA_OP0;
		return a;
	endfunction

endpackage

@@ rtl/postfix_stack_evaluator.sv @@
// postfix_stack_evaluator: microcoded postfix integer evaluator over an operand stack memory
// depends on pse_pkg (constants, control word, program) and pse_div
//
//  channel  signals                          direction  meaning
//  item     item_valid item_ready            in         one character per item
//           symbol[7:0] last_symbol                     character, end-of-expression flag
//  result   result_valid result_ready        out        one item per expression
//           value[15:0] error_code[2:0]                 top of stack, first error
//
// an operator with too few operands skips to the final step, / runs the one-bit-per-cycle
// divider unless the divisor is zero, and the final character of an expression also
// passes through the emit step. one step of the microprogram runs per cycle unless it
// stalls for an item, the divider or a held result; item_ready is high only at the idle step.
// reset clears the sequencer, stack count, error register and result valid; the stack
// memory itself is never cleared. a held result stalls only the emit step.
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [7:0]                     symbol,
	input  logic                           last_symbol,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [pse_pkg::VALUE_BITS-1:0] value,
	output logic [pse_pkg::ERR_W-1:0]      error_code
);

	import pse_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	logic [UPC_W-1:0]       upc_q;
	logic [UPC_W-1:0]       upc_d;
	uword_t                 uw;
	logic [7:0]             sym_q;
	logic                   last_q;
	logic [CW-1:0]          cnt_q;
	logic [ERR_W-1:0]       ferr_q;
	logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
	logic [VALUE_WIDTH-1:0] rdata_q;
	logic [VALUE_WIDTH-1:0] x1_q;
	logic [VALUE_WIDTH-1:0] x2_q;
	logic                   res_valid_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic [ERR_W-1:0]       err_out_q;

	logic                   item_acc;
	logic                   stall;
	logic                   act_en;
	logic                   cnt_lt2;
	logic                   cnt_full;
	logic                   cnt_zero;
	logic [CW-1:0]          cnt_m1;
	logic [CW-1:0]          cnt_m2;
	logic [7:0]             digit;
	logic [VALUE_WIDTH-1:0] alu_res;
	logic                   div_busy;
	logic [VALUE_WIDTH-1:0] div_quo;

	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic                   push;
	logic [VALUE_WIDTH-1:0] push_val;
	logic                   raise;
	logic [ERR_W-1:0]       raise_code;
	logic                   ld_x1;
	logic                   ld_x2;
	logic                   div_start;
	logic                   emit;

	assign uw       = ucode(upc_q);
	assign item_ready = (upc_q == UA_IDLE);
	assign item_acc = item_valid & item_ready;

	assign cnt_lt2  = cnt_q < CW'(2);
	assign cnt_full = cnt_q == CW'(STACK_DEPTH);
	assign cnt_zero = cnt_q == '0;
	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign digit    = sym_q - ASC_ZERO;

	always_comb begin
		priority if (sym_q == ASC_PLUS)
			alu_res = x2_q + x1_q;
		else if (sym_q == ASC_MINUS)
			alu_res = x2_q - x1_q;
		else
			alu_res = x2_q * x1_q;
	end

	assign stall = (uw.jmp == J_DISPATCH && !item_acc) ||
		(uw.jmp == J_WAIT_DIV && div_busy) ||
		(uw.jmp == J_WAIT_OUT && res_valid_q && !result_ready);
	assign act_en = !stall;

	// decode of the control word into datapath strobes
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = cnt_m1[IW-1:0];
		push       = 1'b0;
		push_val   = '0;
		raise      = 1'b0;
		raise_code = ERR_OK;
		ld_x1      = 1'b0;
		ld_x2      = 1'b0;
		div_start  = 1'b0;
		emit       = 1'b0;
		if (act_en) begin
			unique case (uw.act)
				A_PUSH_DIGIT: begin
					push     = 1'b1;
					push_val = VALUE_WIDTH'(digit[3:0]);
				end
				A_ERR_UNKN: begin
					raise      = 1'b1;
					raise_code = ERR_UNKNOWN;
				end
				A_CHK_OPS: begin
					if (cnt_lt2) begin
						raise      = 1'b1;
						raise_code = ERR_UNDERFLOW;
					end else begin
						rd_en = 1'b1;
					end
				end
				A_LD_X1: begin
					ld_x1   = 1'b1;
					rd_en   = 1'b1;
					rd_addr = cnt_m2[IW-1:0];
				end
				A_LD_X2: begin
					ld_x2 = 1'b1;
				end
				A_PUSH_ALU: begin
					push     = 1'b1;
					push_val = alu_res;
				end
				A_DIV_START: begin
					if (x1_q == '0) begin
						raise      = 1'b1;
						raise_code = ERR_DIVZERO;
						push       = 1'b1;
					end else begin
						div_start = 1'b1;
					end
				end
				A_PUSH_QUOT: begin
					push     = 1'b1;
					push_val = div_quo;
				end
				A_RD_TOP: begin
					rd_en = !cnt_zero;
				end
				A_EMIT: begin
					emit = 1'b1;
				end
				default: begin
				end
			endcase
			if (push && cnt_full && !raise) begin
				raise      = 1'b1;
				raise_code = ERR_OVERFLOW;
			end
		end
	end

	always_comb begin
		upc_d = upc_q + 1'b1;
		unique case (uw.jmp)
			J_NEXT:       upc_d = upc_q + 1'b1;
			J_GOTO:       upc_d = uw.tgt;
			J_DISPATCH:   upc_d = item_acc ? dispatch(symbol) : upc_q;
			J_IF_UNDER:   upc_d = cnt_lt2 ? uw.tgt : upc_q + 1'b1;
			J_IF_DIV:     upc_d = (sym_q == ASC_SLASH) ? uw.tgt : upc_q + 1'b1;
			J_IF_ZERO:    upc_d = (x1_q == '0) ? uw.tgt : upc_q + 1'b1;
			J_WAIT_DIV:   upc_d = div_busy ? upc_q : upc_q + 1'b1;
			J_IF_NOTLAST: upc_d = !last_q ? uw.tgt : upc_q + 1'b1;
			J_WAIT_OUT:   upc_d = stall ? upc_q : uw.tgt;
			default:      upc_d = UA_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= UA_IDLE;
			cnt_q       <= '0;
			ferr_q      <= ERR_OK;
			res_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (emit) begin
				cnt_q  <= '0;
				ferr_q <= ERR_OK;
			end else begin
				if (raise && ferr_q == ERR_OK)
					ferr_q <= raise_code;
				if (ld_x2)
					cnt_q <= cnt_m2;
				else if (push && !cnt_full)
					cnt_q <= cnt_q + 1'b1;
			end
			if (emit)
				res_valid_q <= 1'b1;
			else if (result_ready)
				res_valid_q <= 1'b0;
		end
	end

	// operand stack memory, registered read
	always_ff @(posedge clk) begin
		if (push && !cnt_full)
			stack_mem[cnt_q[IW-1:0]] <= push_val;
		if (rd_en)
			rdata_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			sym_q  <= symbol;
			last_q <= last_symbol;
		end
		if (ld_x1)
			x1_q <= rdata_q;
		if (ld_x2)
			x2_q <= rdata_q;
		if (emit) begin
			value_q   <= cnt_zero ? '0 : VALUE_BITS'(rdata_q);
			// an empty stack at the end is an underflow unless an error came first
			err_out_q <= (cnt_zero && ferr_q == ERR_OK) ? ERR_UNDERFLOW : ferr_q;
		end
	end

	pse_div #(
		.W(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (x2_q),
		.divisor  (x1_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign error_code   = err_out_q;

endmodule

@@ rtl/pse_div.sv @@
// pse_div: iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on nothing outside this file
module pse_div #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);

	localparam int CNTW = $clog2(W + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    dsr_q;
	logic [W:0]      shifted;
	logic [W+1:0]    diff;
	logic [W-1:0]    dvd_abs;
	logic [W-1:0]    dsr_abs;

	assign dvd_abs = dividend[W-1] ? (~dividend + 1'b1) : dividend;
	assign dsr_abs = divisor[W-1] ? (~divisor + 1'b1) : divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd_abs;
			dsr_q <= dsr_abs;
			rem_q <= '0;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			// restoring step: keep the difference when it did not borrow
			if (!diff[W+1]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule
